>>> hdl/acl_pkg.sv
// ----------------------------------------------------------------------------
// acl_pkg
// Shared widths, register indexes, reset values and control types for the
// annotation color to label unary energy block.
// ----------------------------------------------------------------------------
package acl_pkg;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ColorW   = 3 * ByteW;
  localparam int unsigned EnergyW  = 16;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned LblCntW  = 5;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  // Hard cap on labels per pixel, set by the 4-bit label fields
  localparam int unsigned LabelCap = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgNumLabels  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgUniformEn  = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgOtherEn    = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgOwnEn      = 4'd3;

  // Register reset values
  localparam logic [LblCntW-1:0] RstNumLabels = 5'd3;
  localparam logic [EnergyW-1:0] RstUniformEn = 16'd4500;
  localparam logic [EnergyW-1:0] RstOtherEn   = 16'd8517;
  localparam logic [EnergyW-1:0] RstOwnEn     = 16'd1178;

  // Controller states
  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StLookup = 3'b010,
    StEmit   = 3'b100
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming pixel
    logic lookup;   // search table, append, latch label
    logic step;     // one result transferred, advance label slot
  } acl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_slot;  // current result is the pixel's final one
  } acl_sts_t;

endpackage

>>> hdl/acl_if.sv
// ----------------------------------------------------------------------------
// acl_if
// Valid/ready channel interfaces: pixel input, result output, config write.
// ----------------------------------------------------------------------------

// Annotation pixel channel
interface acl_pix_if;
  logic                         valid;
  logic                         ready;
  logic [acl_pkg::ByteW-1:0]    red;
  logic [acl_pkg::ByteW-1:0]    green;
  logic [acl_pkg::ByteW-1:0]    blue;
  logic                         end_of_image;

  modport source (output valid, red, green, blue, end_of_image, input ready);
  modport sink   (input valid, red, green, blue, end_of_image, output ready);
endinterface

// Per-label energy result channel
interface acl_res_if;
  logic                         valid;
  logic                         ready;
  logic [acl_pkg::SlotW-1:0]    label_slot;
  logic [acl_pkg::EnergyW-1:0]  energy;
  logic [acl_pkg::SlotW-1:0]    pixel_label;
  logic                         last_of_pixel;
  logic                         image_done;

  modport source (output valid, label_slot, energy, pixel_label, last_of_pixel,
                  image_done, input ready);
  modport sink   (input valid, label_slot, energy, pixel_label, last_of_pixel,
                  image_done, output ready);
endinterface

// Configuration register write channel
interface acl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [acl_pkg::CfgIdxW-1:0]  index;
  logic [acl_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/acl_ctrl.sv
// ----------------------------------------------------------------------------
// acl_ctrl
// Sequencer: accepts a pixel, runs the lookup state, then walks the result
// transfers for every label before taking the next pixel.
// ----------------------------------------------------------------------------
module acl_ctrl import acl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pix_valid_i,
  output logic     pix_ready_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  input  acl_sts_t sts_i,
  output acl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (pix_valid_i) state_d = StLookup;
      end
      StLookup: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (res_ready_i && sts_i.last_slot) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Handshakes and datapath commands
  assign pix_ready_o   = (state_q == StIdle);
  assign res_valid_o   = (state_q == StEmit);
  assign cmd_o.capture = pix_ready_o && pix_valid_i;
  assign cmd_o.lookup  = (state_q == StLookup);
  assign cmd_o.step    = res_valid_o && res_ready_i;

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pix_ready_o && res_valid_o))
    else $error("pixel accepted while results pending");

  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == StLookup))
    else $error("accepted pixel not looked up next cycle");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && sts_i.last_slot) |=> pix_ready_o)
    else $error("final result transfer did not free the block");

endmodule

>>> hdl/acl_dpath.sv
// ----------------------------------------------------------------------------
// acl_dpath
// Config registers, learned color table with fill count, parallel color
// match, label slot counter and result formatting.
// ----------------------------------------------------------------------------
module acl_dpath import acl_pkg::*; #(
  parameter int unsigned MAX_LABELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [ByteW-1:0]    red_i,
  input  logic [ByteW-1:0]    green_i,
  input  logic [ByteW-1:0]    blue_i,
  input  logic                end_of_image_i,
  input  acl_cmd_t            cmd_i,
  output acl_sts_t            sts_o,
  output logic [SlotW-1:0]    label_slot_o,
  output logic [EnergyW-1:0]  energy_o,
  output logic [SlotW-1:0]    pixel_label_o,
  output logic                last_of_pixel_o,
  output logic                image_done_o
);

  // Only the first min(MAX_LABELS, LabelCap) entries can ever be filled
  localparam int unsigned TableDepth = (MAX_LABELS < LabelCap) ? MAX_LABELS : LabelCap;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned HeldW      = $clog2(TableDepth + 1);

  logic [LblCntW-1:0]    num_labels_q;
  logic [EnergyW-1:0]    uniform_en_q, other_en_q, own_en_q;
  logic [ColorW-1:0]     color_q;
  logic                  eoi_q;
  logic [ColorW-1:0]     table_q [TableDepth];
  logic [HeldW-1:0]      held_q;
  logic [IdxW-1:0]       idx_q, idx_d, hit_idx;
  logic                  annot_q, annot_d;
  logic [SlotW-1:0]      slot_q;
  logic [LblCntW-1:0]    eff_labels;
  logic [SlotW-1:0]      last_slot;
  logic [TableDepth-1:0] hit;
  logic                  found, room, append, color_nz;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_labels_q <= RstNumLabels;
      uniform_en_q <= RstUniformEn;
      other_en_q   <= RstOtherEn;
      own_en_q     <= RstOwnEn;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNumLabels: num_labels_q <= cfg_data_i[LblCntW-1:0];
        CfgUniformEn: uniform_en_q <= cfg_data_i;
        CfgOtherEn:   other_en_q   <= cfg_data_i;
        CfgOwnEn:     own_en_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Label count clamped to [2, TableDepth]
  always_comb begin
    if (num_labels_q < LblCntW'(2)) begin
      eff_labels = LblCntW'(2);
    end else if (num_labels_q > LblCntW'(TableDepth)) begin
      eff_labels = LblCntW'(TableDepth);
    end else begin
      eff_labels = num_labels_q;
    end
  end
  assign last_slot = SlotW'(eff_labels - LblCntW'(1));

  // Pixel capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      color_q <= {blue_i, green_i, red_i};
      eoi_q   <= end_of_image_i;
    end
  end

  // Match against filled entries; lowest index wins
  always_comb begin
    hit_idx = '0;
    for (int j = 0; j < TableDepth; j++) begin
      hit[j] = (HeldW'(j) < held_q) && (table_q[j] == color_q);
    end
    for (int j = TableDepth - 1; j >= 0; j--) begin
      if (hit[j]) hit_idx = IdxW'(j);
    end
  end

  assign color_nz = |color_q;
  assign found    = |hit;
  assign room     = LblCntW'(held_q) < eff_labels;
  assign append   = color_nz && !found && room;
  assign annot_d  = color_nz && (found ? (LblCntW'(hit_idx) < eff_labels) : room);
  assign idx_d    = found ? hit_idx : held_q[IdxW-1:0];

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (cmd_i.lookup && append) begin
      held_q <= held_q + HeldW'(1);
    end
  end

  // Color table, appended at the fill count
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup && append) begin
      table_q[held_q[IdxW-1:0]] <= color_q;
    end
  end

  // Lookup outcome
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      idx_q   <= idx_d;
      annot_q <= annot_d;
    end
  end

  // Label slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (cmd_i.lookup) begin
      slot_q <= '0;
    end else if (cmd_i.step) begin
      slot_q <= slot_q + SlotW'(1);
    end
  end

  // Result formatting
  always_comb begin
    if (!annot_q) begin
      energy_o = uniform_en_q;
    end else if (slot_q == SlotW'(idx_q)) begin
      energy_o = own_en_q;
    end else begin
      energy_o = other_en_q;
    end
  end

  assign label_slot_o    = slot_q;
  assign pixel_label_o   = annot_q ? SlotW'(idx_q) : '0;
  assign last_of_pixel_o = (slot_q == last_slot);
  assign image_done_o    = last_of_pixel_o && eoi_q;
  assign sts_o.last_slot = last_of_pixel_o;

  // Checks
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LblCntW'(held_q) <= LblCntW'(TableDepth))
    else $error("fill count beyond table depth");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (slot_q <= last_slot))
    else $error("label slot past label count");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.lookup && append) |=> (held_q == $past(held_q) + HeldW'(1)))
    else $error("append did not bump fill count");

endmodule

>>> hdl/annotation_color_to_label_unary_top.sv
// Flow: a pixel transfer is followed by the table lookup state, then the
//   emit state offers N results, N = num_labels clamped to
//   [2, min(MAX_LABELS, 16)], one result transfer per cycle while the
//   output is ready. The next pixel is taken only after the last result.
// Reset: config registers return to defaults and the fill count clears;
//   the color table holds no data until appended. No clearing pass.
// ----------------------------------------------------------------------------
// annotation_color_to_label_unary_top
// Maps annotation pixel colors to learned labels and emits per-label
// unary energies, one result per label.
// ----------------------------------------------------------------------------
module annotation_color_to_label_unary_top import acl_pkg::*; #(
  parameter int unsigned MAX_LABELS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  acl_pix_if.sink    pix_i,
  acl_res_if.source  res_o,
  acl_cfg_if.sink    cfg_i
);

  acl_cmd_t cmd;
  acl_sts_t sts;

  // Config writes are always taken
  assign cfg_i.ready = 1'b1;

  acl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  acl_dpath #(
    .MAX_LABELS (MAX_LABELS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .red_i           (pix_i.red),
    .green_i         (pix_i.green),
    .blue_i          (pix_i.blue),
    .end_of_image_i  (pix_i.end_of_image),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .label_slot_o    (res_o.label_slot),
    .energy_o        (res_o.energy),
    .pixel_label_o   (res_o.pixel_label),
    .last_of_pixel_o (res_o.last_of_pixel),
    .image_done_o    (res_o.image_done)
  );

endmodule

>>> tb/sv/annotation_color_to_label_unary_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// annotation_color_to_label_unary_top_tb
// Drives annotation pixels and register writes into the label energy block,
// predicts the per-label energies from a shadow color table and shadow
// registers, and checks every result transfer in order against the prediction.
// ----------------------------------------------------------------------------
module annotation_color_to_label_unary_top_tb;
  import acl_pkg::*;

  localparam int unsigned MaxLabels  = 16;
  localparam int unsigned StallLimit = 2000;  // cycles with no transfer at all
  localparam int unsigned TailCycles = 24;
  localparam int unsigned HoldCycles = 200;   // long result back-pressure
  localparam int unsigned PaletteN   = 24;
  localparam int unsigned PhaseN     = 8;
  localparam int unsigned PhaseItems = 40;

  // Register indexes that decode to nothing
  localparam logic [CfgIdxW-1:0] CfgNoRegLo = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgNoRegHi = 4'd15;

  typedef enum logic [1:0] {
    OpPixel,
    OpRegWrite,
    OpDrain
  } stim_kind_e;

  typedef struct packed {
    stim_kind_e            kind;
    logic [ByteW-1:0]      red;
    logic [ByteW-1:0]      green;
    logic [ByteW-1:0]      blue;
    logic                  eoi;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   data;
  } stim_op_t;

  typedef struct packed {
    logic [SlotW-1:0]   label_slot;
    logic [EnergyW-1:0] energy;
    logic [SlotW-1:0]   pixel_label;
    logic               last_of_pixel;
    logic               image_done;
  } energy_rec_t;

  logic clk_i;
  logic rst_ni;

  acl_pix_if pix_if ();
  acl_res_if res_if ();
  acl_cfg_if cfg_if ();

  annotation_color_to_label_unary_top #(
    .MAX_LABELS(MaxLabels)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // Pending stimulus and expected energies
  stim_op_t    stim_q[$];
  energy_rec_t energy_q[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;

  // Shadow registers and learned color table
  logic [LblCntW-1:0] sh_num_labels = RstNumLabels;
  logic [EnergyW-1:0] sh_uniform_en = RstUniformEn;
  logic [EnergyW-1:0] sh_other_en   = RstOtherEn;
  logic [EnergyW-1:0] sh_own_en     = RstOwnEn;
  logic [ColorW-1:0]  learned_colors[MaxLabels];
  int unsigned        colors_learned = 0;

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Labels in use after clamping
  function automatic int unsigned label_count();
    int unsigned n;
    n = sh_num_labels;
    if (n < 2) n = 2;
    if (n > MaxLabels) n = MaxLabels;
    if (n > LabelCap) n = LabelCap;
    return n;
  endfunction

  // Register write as seen by the shadow copy
  task automatic write_shadow_reg(input logic [CfgIdxW-1:0] idx,
                                  input logic [CfgDataW-1:0] data);
    case (idx)
      CfgNumLabels: sh_num_labels = data[LblCntW-1:0];
      CfgUniformEn: sh_uniform_en = data[EnergyW-1:0];
      CfgOtherEn:   sh_other_en   = data[EnergyW-1:0];
      CfgOwnEn:     sh_own_en     = data[EnergyW-1:0];
      default: ;
    endcase
  endtask

  // Look up / learn the color and queue one energy per label
  task automatic predict_energies(input logic [ByteW-1:0] r, g, b, input logic eoi);
    logic [ColorW-1:0] color;
    int unsigned       n;
    int unsigned       idx;
    bit                found;
    bit                annotated;
    energy_rec_t       rec;
    n         = label_count();
    color     = {b, g, r};
    idx       = 0;
    found     = 1'b0;
    annotated = 1'b0;
    if (color != '0) begin
      for (int unsigned j = 0; j < colors_learned; j++) begin
        if (!found && learned_colors[j] == color) begin
          idx   = j;
          found = 1'b1;
        end
      end
      if (found) begin
        annotated = idx < n;
      end else if (colors_learned < n) begin
        learned_colors[colors_learned] = color;
        idx            = colors_learned;
        colors_learned = colors_learned + 1;
        annotated      = 1'b1;
      end
    end
    for (int unsigned j = 0; j < n; j++) begin
      rec.label_slot    = SlotW'(j);
      rec.energy        = !annotated ? sh_uniform_en : (j == idx) ? sh_own_en : sh_other_en;
      rec.pixel_label   = annotated ? SlotW'(idx) : '0;
      rec.last_of_pixel = (j == n - 1);
      rec.image_done    = (j == n - 1) && eoi;
      energy_q.push_back(rec);
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Stimulus queue helpers
  task automatic push_pixel(input logic [ByteW-1:0] r, g, b, input logic eoi);
    stim_op_t op;
    op       = '0;
    op.kind  = OpPixel;
    op.red   = r;
    op.green = g;
    op.blue  = b;
    op.eoi   = eoi;
    stim_q.push_back(op);
  endtask

  task automatic push_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    stim_op_t op;
    op      = '0;
    op.kind = OpRegWrite;
    op.idx  = idx;
    op.data = data;
    stim_q.push_back(op);
  endtask

  task automatic push_drain();
    stim_op_t op;
    op      = '0;
    op.kind = OpDrain;
    stim_q.push_back(op);
  endtask

  // Pixel and register driver: bursts with random gaps, writes only when drained
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : drive_pixels
    logic     pix_fire;
    logic     reg_fire;
    logic     offer_pix;
    logic     offer_reg;
    stim_op_t op;
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      cfg_if.valid <= 1'b0;
    end else begin
      pix_fire = pix_if.valid && pix_if.ready;
      reg_fire = cfg_if.valid && cfg_if.ready;
      if (pix_fire) begin
        predict_energies(pix_if.red, pix_if.green, pix_if.blue, pix_if.end_of_image);
        stim_q.delete(0);
      end
      if (reg_fire) begin
        write_shadow_reg(cfg_if.index, cfg_if.data);
        stim_q.delete(0);
      end
      offer_pix = pix_if.valid && !pix_fire;
      offer_reg = cfg_if.valid && !reg_fire;
      if (!offer_pix && !offer_reg && stim_q.size() != 0) begin
        op = stim_q[0];
        case (op.kind)
          OpPixel: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              offer_pix = 1'b1;
              pix_if.red          <= op.red;
              pix_if.green        <= op.green;
              pix_if.blue         <= op.blue;
              pix_if.end_of_image <= op.eoi;
              if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
              end else begin
                burst_left--;
              end
            end
          end
          OpRegWrite: begin
            if (energy_q.size() == 0) begin
              offer_reg = 1'b1;
              cfg_if.index <= op.idx;
              cfg_if.data  <= op.data;
            end
          end
          default: begin
            // sender pause until every result is back
            if (energy_q.size() == 0) stim_q.delete(0);
          end
        endcase
      end
      pix_if.valid <= offer_pix;
      cfg_if.valid <= offer_reg;
    end
  end

  // Result checker and receiver stall pattern
  int unsigned rx_cycle  = 0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin : check_energies
    energy_rec_t exp_r;
    logic [8:0]  phase_bits;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (energy_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing expected, expected none, got slot %0d energy %0d",
                   $time, res_if.label_slot, res_if.energy);
        end else begin
          exp_r = energy_q.pop_front();
          check_field("label_slot", exp_r.label_slot, res_if.label_slot);
          check_field("energy", exp_r.energy, res_if.energy);
          check_field("pixel_label", exp_r.pixel_label, res_if.pixel_label);
          check_field("last_of_pixel", exp_r.last_of_pixel, res_if.last_of_pixel);
          check_field("image_done", exp_r.image_done, res_if.image_done);
        end
        results_seen++;
        if (results_seen == 300 || results_seen == 1500) hold_left = HoldCycles;
      end
      rx_cycle++;
      phase_bits = rx_cycle[8:0];
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (phase_bits[8:7])
          2'd0:    res_if.ready <= 1'b1;
          2'd1:    res_if.ready <= $urandom_range(0, 1);
          2'd2:    res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= (phase_bits[2:0] != 3'd0);
        endcase
      end
    end
  end

  // Watchdog on cycles without any transfer
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, StallLimit, energy_q.size());
      $display("FAIL annotation_color_to_label_unary_top");
      $finish;
    end
  end

  // Stimulus and end of run
  logic [ColorW-1:0] palette[PaletteN];

  initial begin : run_test
    logic [ColorW-1:0]  color;
    logic [LblCntW-1:0] nl;
    logic [EnergyW-1:0] en;
    int unsigned        pick;
    pix_if.valid        = 1'b0;
    pix_if.red          = '0;
    pix_if.green        = '0;
    pix_if.blue         = '0;
    pix_if.end_of_image = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    res_if.ready        = 1'b0;
    rst_ni              = 1'b0;

    // Reset settings, three labels: black, learning, table full, known colors
    push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'h12, 8'h34, 8'h56, 1'b0);
    push_pixel(8'hFF, 8'h00, 8'h00, 1'b1);
    push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);

    // Sixteen labels (upper data bits masked off), extreme energies, dead indexes
    push_reg(CfgNumLabels, 16'hFFF0);
    push_reg(CfgUniformEn, 16'hFFFF);
    push_reg(CfgOtherEn, 16'h0000);
    push_reg(CfgOwnEn, 16'hFFFF);
    push_reg(CfgNoRegLo, 16'h0001);
    push_reg(CfgNoRegHi, 16'hFFFF);
    push_pixel(8'h12, 8'h34, 8'h56, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h12, 8'h34, 8'h56, 1'b1);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);

    // Label count below range: clamps to two, higher table entries go unannotated
    push_reg(CfgNumLabels, 16'd0);
    push_reg(CfgUniformEn, 16'h0000);
    push_reg(CfgOtherEn, 16'hFFFF);
    push_reg(CfgOwnEn, 16'h0000);
    push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    push_pixel(8'h01, 8'h01, 8'h01, 1'b0);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);

    // Label count above range clamps to sixteen
    push_reg(CfgNumLabels, 16'd31);
    push_pixel(8'h01, 8'h01, 8'h01, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_reg(CfgNumLabels, 16'd1);
    push_pixel(8'hFF, 8'h00, 8'h00, 1'b1);
    push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    push_reg(CfgNumLabels, 16'd17);

    // Palette: colors already seen plus fresh ones, so hits dominate
    palette[0] = 24'h0000FF;
    palette[1] = 24'h00FF00;
    palette[2] = 24'hFF0000;
    palette[3] = 24'h563412;
    palette[4] = 24'hFFFFFF;
    palette[5] = 24'h010101;
    for (int unsigned k = 6; k < PaletteN; k++) palette[k] = ColorW'($urandom_range(1, 24'hFFFFFF));

    // Random phases, each under its own register setting
    for (int unsigned ph = 0; ph < PhaseN; ph++) begin
      case ($urandom_range(0, 7))
        0:       nl = 5'd0;
        1:       nl = 5'd1;
        2:       nl = 5'd2;
        3:       nl = 5'd16;
        4:       nl = LblCntW'($urandom_range(17, 31));
        default: nl = LblCntW'($urandom_range(2, 16));
      endcase
      if (ph == PhaseN - 1) nl = 5'd16;
      push_reg(CfgNumLabels, {11'($urandom), nl});
      for (int unsigned r = 0; r < 3; r++) begin
        case ($urandom_range(0, 3))
          0:       en = 16'h0000;
          1:       en = 16'hFFFF;
          default: en = EnergyW'($urandom);
        endcase
        case (r)
          0:       push_reg(CfgUniformEn, en);
          1:       push_reg(CfgOtherEn, en);
          default: push_reg(CfgOwnEn, en);
        endcase
      end
      if ($urandom_range(0, 2) == 0)
        push_reg(CfgIdxW'($urandom_range(CfgNoRegLo, CfgNoRegHi)), CfgDataW'($urandom));
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) color = palette[$urandom_range(0, PaletteN - 1)];
        else if (pick == 8) color = '0;
        else color = ColorW'($urandom);
        push_pixel(color[7:0], color[15:8], color[23:16], $urandom_range(0, 11) == 0);
        if (k == PhaseItems / 2 && $urandom_range(0, 1) == 0) push_drain();
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || energy_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS annotation_color_to_label_unary_top");
    end else begin
      $display("FAIL annotation_color_to_label_unary_top");
    end
    $finish;
  end

endmodule
